FILE: sv/imt_pkg.sv
// Shared constants, controller states and command/status structs of the interval median tracker.
package imt_pkg;

  // Default ring depth and fixed field widths.
  localparam int unsigned IMT_WINDOW = 100;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned COUNT_W    = 8;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_FILL_DRAIN,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_SWEEP,
    ST_SWEEP_DRAIN,
    ST_CHECK,
    ST_DONE
  } imt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic record;       // store the incoming timestamp
    logic start;        // latch the interval count and rewind the counters
    logic fill_issue;   // read the next stamp, newest first
    logic cand_issue;   // read the current candidate interval
    logic cand_load;    // capture the candidate, clear the rank counters
    logic sweep_issue;  // read the next interval for comparison
    logic check;        // take the candidate or step to the next one
    logic emit;         // load the output register
  } imt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_empty;      // fewer than two stamps stored
    logic fill_last;    // the oldest needed stamp is being read
    logic sweep_last;   // the last interval is being read
    logic found;        // candidate sits at the median rank
    logic out_free;     // output register can take a word
  } imt_stat_t;

endpackage

FILE: sv/imt_in_if.sv
// Input channel of the interval median tracker: valid/ready with action and timestamp.
interface imt_in_if;
  import imt_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, action, timestamp, input ready);
  modport sink   (input valid, action, timestamp, output ready);
endinterface

FILE: sv/imt_out_if.sv
// Output channel of the interval median tracker: valid/ready with median and count.
interface imt_out_if;
  import imt_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] median_interval;
  logic [COUNT_W-1:0] interval_count;

  modport source (output valid, median_interval, interval_count, input ready);
  modport sink   (input valid, median_interval, interval_count, output ready);
endinterface

FILE: sv/imt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module imt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/imt_ctrl.sv
// Controller of the interval median tracker: sequences record, interval fill and rank search.
module imt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  input  imt_pkg::imt_stat_t  stat_i,
  output imt_pkg::imt_cmd_t   cmd_o
);
  import imt_pkg::*;

  imt_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !in_action_i) begin
          cmd_o.record = 1'b1;
        end else if (in_valid_i && in_action_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.q_empty ? ST_DONE : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_issue = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_FILL_DRAIN;
        end
      end
      ST_FILL_DRAIN: begin
        state_d = ST_CAND_RD;
      end
      ST_CAND_RD: begin
        cmd_o.cand_issue = 1'b1;
        state_d          = ST_CAND_LD;
      end
      ST_CAND_LD: begin
        cmd_o.cand_load = 1'b1;
        state_d         = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_issue = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_SWEEP_DRAIN;
        end
      end
      ST_SWEEP_DRAIN: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.found ? ST_DONE : ST_CAND_RD;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/imt_dpath.sv
// Datapath of the interval median tracker: stamp ring, interval store, rank counters, output word.
module imt_dpath #(
  parameter int unsigned WINDOW = imt_pkg::IMT_WINDOW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  imt_pkg::imt_cmd_t             cmd_i,
  output imt_pkg::imt_stat_t            stat_o,
  input  logic [imt_pkg::STAMP_W-1:0]   timestamp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imt_pkg::STAMP_W-1:0]   median_interval_o,
  output logic [imt_pkg::COUNT_W-1:0]   interval_count_o
);
  import imt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] LastSlot = IDX_W'(WINDOW - 1);

  // Control state.
  logic [IDX_W-1:0]  wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              fill_rv_q, sweep_rv_q, have_prev_q, out_valid_q;

  // Working state.
  logic [IDX_W-1:0]   cnt_q, step_q, slot_q, widx_q, ci_q, j_q, less_q, le_q;
  logic [STAMP_W-1:0] prev_q, cand_q, med_q, out_med_q;
  logic [IDX_W-1:0]   out_cnt_q;

  logic [IDX_W-1:0]   cnt_calc, half, ival_raddr;
  logic [STAMP_W-1:0] stamp_rdata, ival_rdata, ival_wdata;
  logic               ival_we;

  // Ring pointer and fill count for a record word.
  assign wp_d   = (wp_q == LastSlot) ? '0 : wp_q + 1'b1;
  assign fill_d = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + 1'b1;

  // Number of intervals: one less than the stored stamps, none below two stamps.
  assign cnt_calc = (fill_q >= FILL_W'(2)) ? IDX_W'(fill_q - 1'b1) : '0;
  assign half     = cnt_q >> 1;

  // Interval store: difference of the previous (newer) and current (older) stamp.
  assign ival_we    = fill_rv_q && have_prev_q;
  assign ival_wdata = prev_q - stamp_rdata;
  assign ival_raddr = cmd_i.sweep_issue ? j_q : ci_q;

  imt_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.record),
    .waddr_i (wp_d),
    .wdata_i (timestamp_i),
    .raddr_i (slot_q),
    .rdata_o (stamp_rdata)
  );

  imt_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW)
  ) u_ival_ram (
    .clk_i   (clk_i),
    .we_i    (ival_we),
    .waddr_i (widx_q),
    .wdata_i (ival_wdata),
    .raddr_i (ival_raddr),
    .rdata_o (ival_rdata)
  );

  // Status toward the controller.
  assign stat_o.q_empty    = (fill_q < FILL_W'(2));
  assign stat_o.fill_last  = (step_q == cnt_q);
  assign stat_o.sweep_last = (j_q == cnt_q - 1'b1);
  assign stat_o.found      = (less_q <= half) && (half < le_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= LastSlot;
      fill_q      <= '0;
      fill_rv_q   <= 1'b0;
      sweep_rv_q  <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_rv_q  <= cmd_i.fill_issue;
      sweep_rv_q <= cmd_i.sweep_issue;
      if (cmd_i.record) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
      end
      if (cmd_i.start) begin
        have_prev_q <= 1'b0;
      end else if (fill_rv_q) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the query.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cnt_q  <= cnt_calc;
      step_q <= '0;
      slot_q <= wp_q;
      widx_q <= '0;
      ci_q   <= '0;
      med_q  <= '0;
    end
    // Walk the ring backward from the newest stamp.
    if (cmd_i.fill_issue) begin
      slot_q <= (slot_q == '0) ? LastSlot : slot_q - 1'b1;
      step_q <= step_q + 1'b1;
    end
    if (fill_rv_q) begin
      prev_q <= stamp_rdata;
    end
    if (ival_we) begin
      widx_q <= widx_q + 1'b1;
    end
    // Candidate capture and rank counting against every interval.
    if (cmd_i.cand_load) begin
      cand_q <= ival_rdata;
      j_q    <= '0;
      less_q <= '0;
      le_q   <= '0;
    end
    if (cmd_i.sweep_issue) begin
      j_q <= j_q + 1'b1;
    end
    if (sweep_rv_q) begin
      less_q <= less_q + IDX_W'(ival_rdata < cand_q);
      le_q   <= le_q + IDX_W'(ival_rdata <= cand_q);
    end
    if (cmd_i.check) begin
      if (stat_o.found) begin
        med_q <= cand_q;
      end else begin
        ci_q <= ci_q + 1'b1;
      end
    end
    // Output word.
    if (cmd_i.emit) begin
      out_med_q <= med_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign median_interval_o = out_med_q;
  assign interval_count_o  = COUNT_W'(out_cnt_q);

endmodule

FILE: sv/interval_median_tracker.sv
// Top level of the interval median tracker: controller, datapath and channel wiring.
//
// The input channel carries one word per event: action 0 records a free-running
// 32-bit tick timestamp into a ring of WINDOW slots; action 1 asks for the upper
// median of the intervals between consecutive stored stamps (at most WINDOW-1
// of them, newest first, differences modulo 2^32). A record word produces no
// output; a query word produces one output word with the median and the number
// of intervals it was taken over (median 0 and count 0 below two stamps).
// A record keeps the controller idle, so the block stays ready for the next word.
// A query first copies the intervals into the interval store, then makes one
// rank pass per candidate, each pass reading the single read port of that
// store once per interval. The result sits in an output register, so record
// words are taken while it waits; a second query finishes its search and then
// holds until the receiver has taken the previous word. Reset (rst_ni low)
// empties the ring and the output register; the stored stamps themselves are
// not cleared.
module interval_median_tracker #(
  parameter int unsigned WINDOW = imt_pkg::IMT_WINDOW
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  imt_in_if.sink    in_i,
  imt_out_if.source out_o
);
  import imt_pkg::*;

  imt_cmd_t  cmd;
  imt_stat_t stat;

  // Sequencer.
  imt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  imt_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .timestamp_i       (in_i.timestamp),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .median_interval_o (out_o.median_interval),
    .interval_count_o  (out_o.interval_count)
  );

endmodule

FILE: tb/imt_tb_pkg.sv
// Action codes of the input word, shared by the stimulus and the scoreboard.
package imt_tb_pkg;

  // Meaning of the action bit of an input word.
  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_QUERY  = 1'b1
  } imt_action_e;

endpackage

FILE: tb/imt_median_checker.sv
// Scoreboard of the interval median tracker: mirrors the stamp ring and checks each result word.
module imt_median_checker #(
  parameter int unsigned WINDOW = imt_pkg::IMT_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imt_in_if           in_i,
  imt_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import imt_pkg::*;
  import imt_tb_pkg::*;

  // One predicted result word.
  typedef struct packed {
    logic [STAMP_W-1:0] median;
    logic [COUNT_W-1:0] count;
  } median_word_t;

  // Mirror of the ring, its newest slot and the number of valid stamps.
  logic [STAMP_W-1:0] stamps [WINDOW];
  int unsigned        newest;
  int unsigned        filled;
  median_word_t       expected_q [$];
  int unsigned        fails = 0;

  // Upper median of the gaps between consecutive stamps, walking back from the newest.
  function automatic median_word_t median_of_gaps();
    logic [STAMP_W-1:0] gaps [$];
    int unsigned        span;
    int unsigned        k;
    median_word_t       word;
    span = (filled >= 2) ? filled - 1 : 0;
    if (span > WINDOW - 1) begin
      span = WINDOW - 1;
    end
    for (k = 0; k < span; k++) begin
      gaps.push_back(stamps[(newest + WINDOW - k) % WINDOW]
                     - stamps[(newest + WINDOW - k - 1) % WINDOW]);
    end
    gaps.sort();
    word.median = (span > 0) ? gaps[span / 2] : '0;
    word.count  = COUNT_W'(span);
    return word;
  endfunction

  // Track accepted input words and compare every accepted result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    median_word_t want;
    if (!rst_ni) begin
      newest = WINDOW - 1;
      filled = 0;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (in_i.valid && in_i.ready) begin
        if (in_i.action == ACT_RECORD) begin
          newest = (newest + 1) % WINDOW;
          stamps[newest] = in_i.timestamp;
          if (filled < WINDOW) begin
            filled++;
          end
        end else begin
          expected_q.push_back(median_of_gaps());
        end
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no query waiting: median_interval %0d, interval_count %0d",
                 out_i.median_interval, out_i.interval_count);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_i.median_interval !== want.median) begin
            $error("median_interval: expected %0d, actual %0d",
                   want.median, out_i.median_interval);
            fails++;
          end
          if (out_i.interval_count !== want.count) begin
            $error("interval_count: expected %0d, actual %0d",
                   want.count, out_i.interval_count);
            fails++;
          end
        end
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: tb/tb_interval_median_tracker.sv
// Testbench top of the interval median tracker: clock, reset, stimulus, watchdog and verdict.
module tb_interval_median_tracker;
  import imt_pkg::*;
  import imt_tb_pkg::*;

  // Cycles allowed with no word moving, long enough for a query over a full ring.
  localparam int unsigned STALL_LIMIT = 50000;

  logic               clk_i;
  logic               rst_ni;
  logic               steady;
  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] last_gap;
  logic [STAMP_W-1:0] base_gap;
  int unsigned        fail_count;
  int unsigned        pending;

  imt_in_if  in_ch ();
  imt_out_if out_ch ();

  interval_median_tracker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  imt_median_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock with a period of two time units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls in about one cycle of five, except during the steady stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  // Abort when no word moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("interval_median_tracker: mismatch");
        $finish;
      end
    end
  end

  // Offer one input word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(input imt_action_e act, input logic [STAMP_W-1:0] stamp);
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.timestamp <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold the sender until every query has been answered.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Next event stamp: mostly a steady beat with jitter, plus repeats, stalls,
  // backward steps, huge jumps and unrelated values.
  function automatic logic [STAMP_W-1:0] next_stamp();
    logic [STAMP_W-1:0] stamp;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      stamp = last_stamp + base_gap + $urandom_range(3);
    end else if (pick < 50) begin
      stamp = last_stamp + last_gap;
    end else if (pick < 60) begin
      stamp = last_stamp;
    end else if (pick < 70) begin
      stamp = last_stamp - $urandom_range(1000, 1);
    end else if (pick < 85) begin
      stamp = last_stamp + $urandom();
    end else begin
      stamp = $urandom();
    end
    last_gap   = stamp - last_stamp;
    last_stamp = stamp;
    return stamp;
  endfunction

  // Reset, directed words, random words, then the verdict.
  initial begin
    int unsigned n;
    int unsigned queries;
    rst_ni          <= 1'b0;
    steady          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_RECORD;
    in_ch.timestamp <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ring, a genuine zero stamp, a single stamp, full-scale and wrapping gaps.
    send_word(ACT_QUERY, $urandom());
    send_word(ACT_RECORD, 32'h0000_0000);
    send_word(ACT_QUERY, $urandom());
    send_word(ACT_RECORD, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, $urandom());
    send_word(ACT_RECORD, 32'h0000_0000);
    send_word(ACT_QUERY, $urandom());
    // Equal gaps, then a stamp going backwards.
    send_word(ACT_RECORD, 32'd5);
    send_word(ACT_RECORD, 32'd10);
    send_word(ACT_RECORD, 32'd3);
    send_word(ACT_QUERY, $urandom());
    send_word(ACT_RECORD, 32'd13);
    send_word(ACT_RECORD, 32'd23);
    send_word(ACT_QUERY, $urandom());
    send_word(ACT_RECORD, 32'hAAAA_AAAA);
    send_word(ACT_RECORD, 32'h5555_5555);
    send_word(ACT_QUERY, $urandom());
    queries = 7;

    // Random traffic; enough records to wrap the ring and cap the interval count.
    last_stamp = 32'h5555_5555;
    base_gap   = $urandom_range(5000, 50);
    last_gap   = base_gap;
    for (n = 0; n < 120 || queries < 30; n++) begin
      if (n == 30) begin
        steady <= 1'b1;
      end
      if (n == 70) begin
        steady <= 1'b0;
      end
      if (n == 60 || n == 100) begin
        drain_results();
      end
      if ($urandom_range(99) < 20) begin
        send_word(ACT_QUERY, $urandom());
        queries++;
      end else begin
        send_word(ACT_RECORD, next_stamp());
      end
    end

    // Let the last answers arrive, then watch for stray words.
    drain_results();
    repeat (50) @(posedge clk_i);
    if (pending != 0) begin
      $error("%0d query results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("interval_median_tracker: match");
    end else begin
      $display("interval_median_tracker: mismatch");
    end
    $finish;
  end

endmodule
